>>> hdl/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    localparam logic [2:0] CFG_KEY0   = 3'd0;
    localparam logic [2:0] CFG_KEY1   = 3'd1;
    localparam logic [2:0] CFG_KEY2   = 3'd2;
    localparam logic [2:0] CFG_KEY3   = 3'd3;
    localparam logic [2:0] CFG_KEYLEN = 3'd4;
    localparam logic [2:0] CFG_IVHI   = 3'd5;
    localparam logic [2:0] CFG_IVLO   = 3'd6;
    localparam logic [2:0] CFG_MODE   = 3'd7;

    localparam logic [1:0] MODE_ECB_ENC = 2'd0;
    localparam logic [1:0] MODE_ECB_DEC = 2'd1;
    localparam logic [1:0] MODE_CBC_ENC = 2'd2;
    localparam logic [1:0] MODE_CBC_DEC = 2'd3;

    localparam logic [1:0] KEYLEN_128 = 2'd0;
    localparam logic [1:0] KEYLEN_192 = 2'd1;

    localparam int RK_DEPTH = 60;

    localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte 0 of the block sits in bits 127:120; column c holds bytes 4c..4c+3.
    function automatic block_t enc_round(input block_t s, input logic last_round);
        block_t t;
        block_t m;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32*c -: 8];
            a1 = t[119 - 32*c -: 8];
            a2 = t[111 - 32*c -: 8];
            a3 = t[103 - 32*c -: 8];
            m[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            m[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            m[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            m[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return last_round ? t : m;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t m;
        byte_t a [4];
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = s[127 - 32*c - 8*k -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                // Coefficients 0e, 0b, 0d, 09 rotated by row.
                m[127 - 32*c - 8*r -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return m;
    endfunction

    function automatic block_t inv_sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*((c + r) % 4) + r) -: 8] = RSBOX[s[127 - 8*(4*c + r) -: 8]];
            end
        end
        return t;
    endfunction

endpackage

>>> hdl/aes_key_expand.sv
`timescale 1ns / 1ps

// Key schedule: one 32-bit word per cycle into the round-key memory.
module aes_key_expand (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [255:0] key,
    input  logic [1:0]  key_len,
    output logic        busy,
    output logic        wr_en,
    output logic [5:0]  wr_addr,
    output logic [31:0] wr_data
);

    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [8];
    logic [31:0] win_next [8];
    logic [3:0]  nk;
    logic [5:0]  total;
    logic [31:0] t;
    logic [31:0] w_new;

    always_comb begin
        unique case (key_len)
            aes_pkg::KEYLEN_128: nk = 4'd4;
            aes_pkg::KEYLEN_192: nk = 4'd6;
            default:             nk = 4'd8;
        endcase
        total = 6'({nk, 2'b00} + 6'd28);
    end

    // The last nk words live in a sliding window; win[nk-1] is the newest.
    always_comb begin
        t = win_reg[3'(nk - 4'd1)];
        if (phase_reg == 3'd0) begin
            t = aes_pkg::sbox_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && phase_reg == 3'd4) begin
            t = aes_pkg::sbox_word(t);
        end
        w_new = (idx_reg < 6'(nk)) ? key[255 - 32*idx_reg[2:0] -: 32] : (win_reg[0] ^ t);
        for (int i = 0; i < 8; i++) begin
            win_next[i] = win_reg[i];
        end
        idx_next   = idx_reg;
        phase_next = phase_reg;
        rcon_next  = rcon_reg;
        busy_next  = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next = '0;
            phase_next = '0;
            rcon_next = 8'h01;
        end else if (busy_reg) begin
            if (idx_reg < 6'(nk)) begin
                win_next[idx_reg[2:0]] = w_new;
            end else begin
                for (int i = 0; i < 7; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[3'(nk - 4'd1)] = w_new;
                if (phase_reg == 3'd0) begin
                    rcon_next = aes_pkg::xtime(rcon_reg);
                end
            end
            if (idx_reg >= 6'(nk)) begin
                phase_next = (phase_reg == 3'(nk - 4'd1)) ? 3'd0 : 3'(phase_reg + 3'd1);
            end
            idx_next = 6'(idx_reg + 6'd1);
            if (idx_reg == 6'(total - 6'd1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            rcon_reg  <= rcon_next;
        end
        for (int i = 0; i < 8; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    assign busy    = busy_reg;
    assign wr_en   = busy_reg && !start;
    assign wr_addr = idx_reg;
    assign wr_data = w_new;

endmodule

>>> hdl/aes_block_cipher_cbc_core.sv
`timescale 1ns / 1ps

// AES block engine, ECB and CBC, 128/192/256-bit keys.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// the user writes only while the engine is idle (the block does not enforce
// it). A key or key-length write forces a new key expansion when the next
// block is offered: one word a cycle into a 60 x 32 round-key RAM, and that
// block is accepted once it ends. IV or mode writes reload the chain.
// Input beats on s_axis carry one 128-bit block; tuser is last_block.
// One block is processed at a time. The round-key RAM has one registered
// read port and four words are read per round; each round is applied when
// its fourth word arrives. Once the result is valid, the engine is idle
// again and can accept the next beat. The result waits in an output
// register; the next input beat is accepted while a result is still held,
// and the result register is reloaded only once the receiver has taken the
// previous beat. A stalled receiver therefore holds the input off after one
// more block.
// Reset clears all configuration to zero and discards any work in flight.
module aes_block_cipher_cbc_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  logic         s_axis_tuser,   // last_block
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
    output logic         m_axis_tuser    // result_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [63:0] key_reg [4];
    logic [1:0]  klen_reg, mode_reg;
    logic [63:0] ivh_reg, ivl_reg;
    logic [127:0] chain_reg;
    logic        expanded_reg;
    logic [2:0]  state_reg;

    logic [127:0] st_reg;
    logic [127:0] in_reg;
    logic         last_reg;
    logic [3:0]  rnd_reg;
    logic [2:0]  col_reg;
    logic [95:0] kacc_reg;
    logic [127:0] res_reg;
    logic         res_last_reg;
    logic         res_valid_reg;

    logic [31:0] rk_mem [aes_pkg::RK_DEPTH];
    logic [31:0] rk_rd_reg;

    logic        kx_start, kx_busy, kx_we;
    logic [5:0]  kx_addr;
    logic [31:0] kx_data;
    logic [3:0]  nr;
    logic        dec;
    logic [3:0]  kround;
    logic [5:0]  rd_addr;
    logic [127:0] rk;
    logic [127:0] blk_in;
    logic [127:0] x;
    logic [127:0] raw;

    assign nr  = (klen_reg == aes_pkg::KEYLEN_128) ? 4'd10 :
                 (klen_reg == aes_pkg::KEYLEN_192) ? 4'd12 : 4'd14;
    assign dec = mode_reg[0];

    aes_key_expand u_kx (
        .aclk(aclk), .aresetn(aresetn), .start(kx_start),
        .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .key_len(klen_reg), .busy(kx_busy), .wr_en(kx_we),
        .wr_addr(kx_addr), .wr_data(kx_data)
    );

    assign kx_start = (state_reg == ST_IDLE) && s_axis_tvalid && !expanded_reg;
    assign s_axis_tready = (state_reg == ST_IDLE) && expanded_reg;

    // Round key index in processing order; decryption walks the rounds backwards.
    assign kround  = dec ? 4'(nr - rnd_reg) : rnd_reg;
    assign rd_addr = 6'({kround, 2'b00} + {4'd0, col_reg[1:0]});

    always_ff @(posedge aclk) begin
        if (kx_we) begin
            rk_mem[kx_addr] <= kx_data;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    assign rk = {kacc_reg, rk_rd_reg};
    assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    // One round of the datapath, applied when the fourth key word arrives.
    always_comb begin
        if (!dec) begin
            if (rnd_reg == 4'd0) x = st_reg ^ rk;
            else x = aes_pkg::enc_round(st_reg, rnd_reg == nr) ^ rk;
        end else begin
            if (rnd_reg == 4'd0) x = st_reg ^ rk;
            else if (rnd_reg == nr) x = aes_pkg::inv_sub_shift(st_reg) ^ rk;
            else x = aes_pkg::inv_sub_shift(st_reg) ^ rk;
        end
        raw = x;
        if (dec && rnd_reg != 4'd0 && rnd_reg != nr) raw = aes_pkg::inv_mix(x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            klen_reg <= '0;
            mode_reg <= '0;
            ivh_reg <= '0;
            ivl_reg <= '0;
            chain_reg <= '0;
            expanded_reg <= 1'b0;
            state_reg <= ST_IDLE;
            rnd_reg <= '0;
            col_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!res_valid_reg || m_axis_tready)) begin
                res_valid_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    aes_pkg::CFG_KEY0, aes_pkg::CFG_KEY1, aes_pkg::CFG_KEY2,
                    aes_pkg::CFG_KEY3: begin
                        key_reg[cfg_addr[1:0]] <= cfg_wdata;
                        expanded_reg <= 1'b0;
                    end
                    aes_pkg::CFG_KEYLEN: begin
                        klen_reg <= cfg_wdata[1:0];
                        expanded_reg <= 1'b0;
                    end
                    aes_pkg::CFG_IVHI: begin
                        ivh_reg <= cfg_wdata;
                        chain_reg <= {cfg_wdata, ivl_reg};
                    end
                    aes_pkg::CFG_IVLO: begin
                        ivl_reg <= cfg_wdata;
                        chain_reg <= {ivh_reg, cfg_wdata};
                    end
                    default: begin
                        mode_reg <= cfg_wdata[1:0];
                        chain_reg <= {ivh_reg, ivl_reg};
                    end
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (kx_start) begin
                        state_reg <= ST_KEY;
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        state_reg <= ST_RUN;
                        rnd_reg <= '0;
                        col_reg <= '0;
                    end
                end
                ST_KEY: begin
                    if (!kx_busy) begin
                        expanded_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    // col 0..3 issue reads; data for col k arrives at col k+1.
                    if (col_reg == 3'd4) begin
                        col_reg <= '0;
                        if (rnd_reg == nr) begin
                            state_reg <= ST_OUT;
                        end else begin
                            rnd_reg <= 4'(rnd_reg + 4'd1);
                        end
                    end else begin
                        col_reg <= 3'(col_reg + 3'd1);
                    end
                end
                ST_OUT: begin
                    if (!res_valid_reg || m_axis_tready) begin
                        state_reg <= ST_IDLE;
                        if (last_reg) chain_reg <= {ivh_reg, ivl_reg};
                        else if (mode_reg == aes_pkg::MODE_CBC_ENC) chain_reg <= st_reg;
                        else if (mode_reg == aes_pkg::MODE_CBC_DEC) chain_reg <= in_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
            in_reg <= blk_in;
            last_reg <= s_axis_tuser;
            st_reg <= (mode_reg == aes_pkg::MODE_CBC_ENC) ? (blk_in ^ chain_reg) : blk_in;
        end
        if (state_reg == ST_RUN && col_reg != 3'd0) begin
            if (col_reg == 3'd4) begin
                st_reg <= (rnd_reg == nr) ? x : raw;
            end else begin
                kacc_reg <= {kacc_reg[63:0], rk_rd_reg};
            end
        end
        if (state_reg == ST_OUT && (!res_valid_reg || m_axis_tready)) begin
            res_reg <= (mode_reg == aes_pkg::MODE_CBC_DEC) ? (st_reg ^ chain_reg) : st_reg;
            res_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {res_reg[63:0], res_reg[127:64]};
    assign m_axis_tuser  = res_last_reg;

    a_key_before_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> expanded_reg)
        else $error("block processed without expanded keys");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } blk_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [63:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;

    aes_block_cipher_cbc_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Shadow copy of the engine's configuration and state.
    logic [63:0] sh_key [4];
    logic [1:0]  sh_klen;
    logic [1:0]  sh_mode;
    logic [63:0] sh_iv_hi, sh_iv_lo;
    logic [63:0] sh_chain [2];
    logic        sh_expanded;
    logic [31:0] rkey [60];
    aes_pkg::byte_t inv_tbl [256];
    aes_pkg::byte_t st [16];

    blk_t pending_blocks [$];
    blk_t cipher_results [$];
    blk_t cur_blk;
    int   mismatches;
    int   stall_cnt;
    int   hold_cnt;
    logic hold_req, hold_done;
    logic no_idle;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic aes_pkg::byte_t gmul(aes_pkg::byte_t a, aes_pkg::byte_t b);
        aes_pkg::byte_t p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic int key_nk();
        return sh_klen == aes_pkg::KEYLEN_128 ? 4 : (sh_klen == aes_pkg::KEYLEN_192 ? 6 : 8);
    endfunction

    function automatic logic [31:0] subw(logic [31:0] w);
        return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
                aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk;
        logic [31:0] t;
        aes_pkg::byte_t rc;
        nk = key_nk();
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            rkey[i] = i[0] ? sh_key[i >> 1][31:0] : sh_key[i >> 1][63:32];
        for (int i = nk; i < 4 * (nk + 7); i++) begin
            t = rkey[i - 1];
            if (i % nk == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            rkey[i] = rkey[i - nk] ^ t;
        end
        sh_expanded = 1'b1;
    endfunction

    function automatic void xor_round_key(int rnd);
        logic [31:0] k;
        for (int c = 0; c < 4; c++) begin
            k = rkey[(4 * rnd + c) % 60];
            for (int b = 0; b < 4; b++) st[4*c + b] ^= k[31 - 8*b -: 8];
        end
    endfunction

    function automatic void rotate_rows(logic inv);
        aes_pkg::byte_t t [16];
        t = st;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (inv) st[4*((c + r) & 3) + r] = t[4*c + r];
                else st[4*c + r] = t[4*((c + r) & 3) + r];
            end
    endfunction

    function automatic void mix_cols(logic inv);
        aes_pkg::byte_t coef [4];
        aes_pkg::byte_t a [4];
        aes_pkg::byte_t v;
        if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = st[4*c + k];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gmul(a[k], coef[(k + 4 - r) & 3]);
                st[4*c + r] = v;
            end
        end
    endfunction

    function automatic void cipher_fwd(int nr);
        xor_round_key(0);
        for (int r = 1; r <= nr; r++) begin
            for (int i = 0; i < 16; i++) st[i] = aes_pkg::SBOX[st[i]];
            rotate_rows(1'b0);
            if (r < nr) mix_cols(1'b0);
            xor_round_key(r);
        end
    endfunction

    function automatic void cipher_inv(int nr);
        xor_round_key(nr);
        for (int r = nr - 1; r >= 0; r--) begin
            rotate_rows(1'b1);
            for (int i = 0; i < 16; i++) st[i] = inv_tbl[st[i]];
            xor_round_key(r);
            if (r > 0) mix_cols(1'b1);
        end
    endfunction

    function automatic void load_state(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < 8; i++) begin
            st[i] = hi[63 - 8*i -: 8];
            st[8 + i] = lo[63 - 8*i -: 8];
        end
    endfunction

    function automatic logic [127:0] read_state();
        logic [127:0] v;
        for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = st[i];
        return v;
    endfunction

    // Computes the result for one accepted block and advances the chain.
    function automatic void predict_block(blk_t b);
        blk_t r;
        logic [127:0] v;
        int nr;
        if (!sh_expanded) expand_schedule();
        nr = key_nk() + 6;
        case (sh_mode)
            aes_pkg::MODE_ECB_ENC: begin
                load_state(b.hi, b.lo);
                cipher_fwd(nr);
                v = read_state();
            end
            aes_pkg::MODE_ECB_DEC: begin
                load_state(b.hi, b.lo);
                cipher_inv(nr);
                v = read_state();
            end
            aes_pkg::MODE_CBC_ENC: begin
                load_state(b.hi ^ sh_chain[0], b.lo ^ sh_chain[1]);
                cipher_fwd(nr);
                v = read_state();
                sh_chain[0] = v[127:64];
                sh_chain[1] = v[63:0];
            end
            default: begin
                load_state(b.hi, b.lo);
                cipher_inv(nr);
                v = read_state() ^ {sh_chain[0], sh_chain[1]};
                sh_chain[0] = b.hi;
                sh_chain[1] = b.lo;
            end
        endcase
        if (b.last) begin
            sh_chain[0] = sh_iv_hi;
            sh_chain[1] = sh_iv_lo;
        end
        r.hi = v[127:64];
        r.lo = v[63:0];
        r.last = b.last;
        cipher_results.push_back(r);
    endfunction

    // Driver: presents pending blocks, holding each until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_block(cur_blk);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_blocks.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
                    cur_blk = pending_blocks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_blk.lo, cur_blk.hi};
                    s_axis_tuser <= cur_blk.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure, with one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    // Monitor: checks every output beat against the oldest prediction.
    always @(posedge aclk) begin
        blk_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (cipher_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat %h last %b", m_axis_tdata, m_axis_tuser);
            end else begin
                e = cipher_results.pop_front();
                if (m_axis_tdata[63:0] !== e.hi || m_axis_tdata[127:64] !== e.lo ||
                    m_axis_tuser !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hi %h lo %h last %b, got hi %h lo %h last %b",
                                 e.hi, e.lo, e.last, m_axis_tdata[63:0],
                                 m_axis_tdata[127:64], m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles without progress while work is outstanding.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_blocks.size() == 0 && !s_axis_tvalid && cipher_results.size() == 0)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            aes_pkg::CFG_KEY0, aes_pkg::CFG_KEY1, aes_pkg::CFG_KEY2,
            aes_pkg::CFG_KEY3: begin
                sh_key[idx[1:0]] = val;
                sh_expanded = 1'b0;
            end
            aes_pkg::CFG_KEYLEN: begin
                sh_klen = val[1:0];
                sh_expanded = 1'b0;
            end
            aes_pkg::CFG_IVHI: sh_iv_hi = val;
            aes_pkg::CFG_IVLO: sh_iv_lo = val;
            default: sh_mode = val[1:0];
        endcase
        if (idx >= aes_pkg::CFG_IVHI) begin
            sh_chain[0] = sh_iv_hi;
            sh_chain[1] = sh_iv_lo;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_blocks.size() > 0 || s_axis_tvalid || cipher_results.size() > 0)
            @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_block(logic [63:0] hi, logic [63:0] lo, logic last);
        blk_t b;
        b.hi = hi;
        b.lo = lo;
        b.last = last;
        pending_blocks.push_back(b);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_block(rand_word(), rand_word(), $urandom_range(5) == 0);
    endtask

    initial begin
        int nb;
        for (int i = 0; i < 256; i++) inv_tbl[aes_pkg::SBOX[i]] = i[7:0];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = aes_pkg::CFG_KEY0;
        cfg_wdata = 64'h0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        mismatches = 0;
        for (int i = 0; i < 4; i++) sh_key[i] = 64'h0;
        sh_klen = aes_pkg::KEYLEN_128;
        sh_mode = aes_pkg::MODE_ECB_ENC;
        sh_iv_hi = 64'h0;
        sh_iv_lo = 64'h0;
        sh_chain[0] = 64'h0;
        sh_chain[1] = 64'h0;
        sh_expanded = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration first: all-zero 128-bit key, ECB encrypt.
        @(negedge aclk);
        queue_block(64'h0, 64'h0, 1'b0);
        queue_block('1, '1, 1'b1);
        drain();

        // Standard 128-bit key with each mode in turn.
        write_reg(aes_pkg::CFG_KEY0, 64'h0001020304050607);
        write_reg(aes_pkg::CFG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(aes_pkg::CFG_IVHI, 64'hffeeddccbbaa9988);
        write_reg(aes_pkg::CFG_IVLO, 64'h7766554433221100);
        for (int m = 0; m < 4; m++) begin
            write_reg(aes_pkg::CFG_MODE, 64'(m));
            @(negedge aclk);
            queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
            queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
            queue_block('1, 64'h0, 1'b0);
            queue_block(64'h0, '1, 1'b1);
            drain();
        end

        // Longer keys, including the saturating key length code.
        write_reg(aes_pkg::CFG_KEY2, 64'h1011121314151617);
        write_reg(aes_pkg::CFG_KEY3, 64'h18191a1b1c1d1e1f);
        for (int k = 1; k < 4; k++) begin
            write_reg(aes_pkg::CFG_KEYLEN, 64'(k));
            write_reg(aes_pkg::CFG_MODE,
                      64'((k == 3) ? aes_pkg::MODE_CBC_DEC : aes_pkg::MODE_CBC_ENC));
            @(negedge aclk);
            queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
            queue_block('1, '1, 1'b1);
            drain();
        end

        // Random phases; each reconfigures some registers, all of them at first.
        for (int ph = 0; ph < 30; ph++) begin
            for (int r = 0; r < 8; r++) begin
                if (ph == 0 || $urandom_range(2) == 0) begin
                    if (r == aes_pkg::CFG_KEYLEN) write_reg(r[2:0], 64'($urandom_range(3)));
                    else if (r == aes_pkg::CFG_MODE) write_reg(r[2:0], 64'($urandom_range(3)));
                    else write_reg(r[2:0], rand_word());
                end
            end
            @(negedge aclk);
            no_idle <= (ph == 5);
            if (ph == 10) hold_req <= 1'b1;
            nb = (ph == 10) ? 40 : $urandom_range(10, 30);
            queue_random(nb);
            drain();
        end

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && cipher_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
